>>> src/qrs_pkg.sv
// ---------------------------------------------------------------------------
// qrs_pkg: shared constants and types of the quadratic root solver
// Result field widths, fixed-point scaling and the saturation limits.
// ---------------------------------------------------------------------------
`default_nettype none
package qrs_pkg;

    localparam int DISC_BITS  = 34;
    localparam int ROOT_BITS  = 32;
    localparam int FRAC_SHIFT = 16;

    // Largest quotient magnitudes that still fit a signed 32-bit root.
    localparam logic [ROOT_BITS:0] ROOT_POS_LIMIT = 33'h0_7FFF_FFFF;
    localparam logic [ROOT_BITS:0] ROOT_NEG_LIMIT = 33'h0_8000_0000;

    localparam logic [ROOT_BITS-1:0] ROOT_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [ROOT_BITS-1:0] ROOT_NEG_MIN = 32'h8000_0000;

    typedef struct packed {
        logic no_real_roots;
        logic not_quadratic;
    } t_qrs_flags;

endpackage
`default_nettype wire

>>> src/qrs_in_if.sv
// ---------------------------------------------------------------------------
// qrs_in_if: request channel of the quadratic root solver
// Valid/ready channel carrying the three Q8.8 coefficients.
// ---------------------------------------------------------------------------
`default_nettype none
interface qrs_in_if #(
    parameter int COEF_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;

    modport source(output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink(input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface
`default_nettype wire

>>> src/qrs_out_if.sv
// ---------------------------------------------------------------------------
// qrs_out_if: result channel of the quadratic root solver
// Valid/ready channel carrying the discriminant, both roots and the flags.
// ---------------------------------------------------------------------------
`default_nettype none
interface qrs_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [qrs_pkg::DISC_BITS-1:0]  discriminant;
    logic signed [qrs_pkg::ROOT_BITS-1:0]  root_plus;
    logic signed [qrs_pkg::ROOT_BITS-1:0]  root_minus;
    logic                                  no_real_roots;
    logic                                  not_quadratic;
    logic                                  root_saturated;

    modport source(output valid, output discriminant, output root_plus, output root_minus,
                   output no_real_roots, output not_quadratic, output root_saturated,
                   input ready);
    modport sink(input valid, input discriminant, input root_plus, input root_minus,
                 input no_real_roots, input not_quadratic, input root_saturated,
                 output ready);
endinterface
`default_nettype wire

>>> src/qrs_sqrt_cell.sv
// ---------------------------------------------------------------------------
// qrs_sqrt_cell: one digit of the integer square root chain
// Brings in two radicand bits, decides one root bit, passes the side data on.
// ---------------------------------------------------------------------------
`default_nettype none
module qrs_sqrt_cell #(
    parameter int DW  = 34,
    parameter int SW  = 17,
    parameter int PLW = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [DW-1:0]   i_v,
    input  wire logic [SW+1:0]   i_rem,
    input  wire logic [SW-1:0]   i_root,
    input  wire logic [PLW-1:0]  i_pl,
    output logic                 o_valid,
    output logic      [DW-1:0]   o_v,
    output logic      [SW+1:0]   o_rem,
    output logic      [SW-1:0]   o_root,
    output logic      [PLW-1:0]  o_pl
);
    logic [SW+3:0] w_acc;
    logic [SW+3:0] w_trial;
    logic [SW+1:0] n_rem;
    logic [SW-1:0] n_root;
    logic          r_valid;
    logic [DW-1:0] r_v;
    logic [SW+1:0] r_rem;
    logic [SW-1:0] r_root;
    logic [PLW-1:0] r_pl;

    always_comb begin
        w_acc   = {i_rem, i_v[DW-1 -: 2]};
        w_trial = {2'b00, i_root, 2'b01};
        if (w_acc >= w_trial) begin
            n_rem  = (SW+2)'(w_acc - w_trial);
            n_root = {i_root[SW-2:0], 1'b1};
        end else begin
            n_rem  = w_acc[SW+1:0];
            n_root = {i_root[SW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= {i_v[DW-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
            r_pl   <= i_pl;
        end
    end

    assign o_valid = r_valid;
    assign o_v     = r_v;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_pl    = r_pl;
endmodule
`default_nettype wire

>>> src/qrs_div_cell.sv
// ---------------------------------------------------------------------------
// qrs_div_cell: one quotient bit of the two-lane restoring divider chain
// Both roots share the divisor; each lane shifts in one dividend bit.
// ---------------------------------------------------------------------------
`default_nettype none
module qrs_div_cell #(
    parameter int DNW = 35,
    parameter int ADW = 17,
    parameter int PLW = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [ADW-1:0]  i_den,
    input  wire logic [DNW-1:0]  i_num_p,
    input  wire logic [DNW-1:0]  i_num_m,
    input  wire logic [ADW-1:0]  i_rem_p,
    input  wire logic [ADW-1:0]  i_rem_m,
    input  wire logic [DNW-1:0]  i_quo_p,
    input  wire logic [DNW-1:0]  i_quo_m,
    input  wire logic [PLW-1:0]  i_pl,
    output logic                 o_valid,
    output logic      [ADW-1:0]  o_den,
    output logic      [DNW-1:0]  o_num_p,
    output logic      [DNW-1:0]  o_num_m,
    output logic      [ADW-1:0]  o_rem_p,
    output logic      [ADW-1:0]  o_rem_m,
    output logic      [DNW-1:0]  o_quo_p,
    output logic      [DNW-1:0]  o_quo_m,
    output logic      [PLW-1:0]  o_pl
);
    logic [ADW:0]   w_acc_p;
    logic [ADW:0]   w_acc_m;
    logic [ADW:0]   w_den;
    logic [ADW-1:0] n_rem_p;
    logic [ADW-1:0] n_rem_m;
    logic           n_bit_p;
    logic           n_bit_m;
    logic           r_valid;
    logic [ADW-1:0] r_den;
    logic [DNW-1:0] r_num_p;
    logic [DNW-1:0] r_num_m;
    logic [ADW-1:0] r_rem_p;
    logic [ADW-1:0] r_rem_m;
    logic [DNW-1:0] r_quo_p;
    logic [DNW-1:0] r_quo_m;
    logic [PLW-1:0] r_pl;

    always_comb begin
        w_den   = {1'b0, i_den};
        w_acc_p = {i_rem_p, i_num_p[DNW-1]};
        w_acc_m = {i_rem_m, i_num_m[DNW-1]};
        n_bit_p = (w_acc_p >= w_den);
        n_bit_m = (w_acc_m >= w_den);
        n_rem_p = n_bit_p ? ADW'(w_acc_p - w_den) : w_acc_p[ADW-1:0];
        n_rem_m = n_bit_m ? ADW'(w_acc_m - w_den) : w_acc_m[ADW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den   <= i_den;
            r_num_p <= {i_num_p[DNW-2:0], 1'b0};
            r_num_m <= {i_num_m[DNW-2:0], 1'b0};
            r_rem_p <= n_rem_p;
            r_rem_m <= n_rem_m;
            r_quo_p <= {i_quo_p[DNW-2:0], n_bit_p};
            r_quo_m <= {i_quo_m[DNW-2:0], n_bit_m};
            r_pl    <= i_pl;
        end
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_num_p = r_num_p;
    assign o_num_m = r_num_m;
    assign o_rem_p = r_rem_p;
    assign o_rem_m = r_rem_m;
    assign o_quo_p = r_quo_p;
    assign o_quo_m = r_quo_m;
    assign o_pl    = r_pl;
endmodule
`default_nettype wire

>>> src/quadratic_root_solver_unit.sv
// ---------------------------------------------------------------------------
// quadratic_root_solver_unit: real roots of a*x^2 + b*x + c in fixed point
// Input register, multiplier stage, discriminant stage, a square root chain,
// a numerator stage, a two-lane divider chain and an output register.
// ---------------------------------------------------------------------------
// The square root chain decides one root bit per cell and the divider chain
// one quotient bit per cell.
// Throughput: one request per cycle; the whole pipeline stalls only while a
// finished result waits at the output register.
// Reset empties the pipeline; no state survives between requests.
`default_nettype none
module quadratic_root_solver_unit #(
    parameter int COEF_WIDTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qrs_in_if.sink     i_req,
    qrs_out_if.source  o_res
);
    localparam int CW   = COEF_WIDTH;
    localparam int DW   = (2*CW+2 > 64) ? 64 : 2*CW+2;
    localparam int SW   = DW / 2;
    localparam int NW   = ((CW > SW) ? CW : SW) + 2;
    localparam int DNW  = NW + qrs_pkg::FRAC_SHIFT;
    localparam int ADW  = CW + 1;
    localparam int RB   = qrs_pkg::ROOT_BITS;
    localparam int QX   = (DNW > RB+1) ? DNW : RB+1;
    localparam int DB   = qrs_pkg::DISC_BITS;
    localparam int PLS  = DB + 2*CW + 2;
    localparam int PLD  = DB + 4;

    logic w_adv;

    // Input register.
    logic                 r_v1;
    logic signed [CW-1:0] r_a1, r_b1, r_c1;
    // Products.
    logic                   r_v2;
    logic signed [2*CW-1:0] r_bb, r_ac;
    logic signed [CW-1:0]   r_a2, r_b2;
    // Discriminant.
    logic                 r_v3;
    logic signed [DW-1:0] r_disc;
    logic signed [CW-1:0] r_a3, r_b3;
    logic signed [DW-1:0] w_ac4;
    logic signed [DW-1:0] w_disc;
    qrs_pkg::t_qrs_flags  w_flags3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        w_ac4  = DW'(r_ac);
        w_disc = DW'(r_bb) - (w_ac4 << 2);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a1   <= i_req.coef_a;
            r_b1   <= i_req.coef_b;
            r_c1   <= i_req.coef_c;
            r_bb   <= r_b1 * r_b1;
            r_ac   <= r_a1 * r_c1;
            r_a2   <= r_a1;
            r_b2   <= r_b1;
            r_disc <= w_disc;
            r_a3   <= r_a2;
            r_b3   <= r_b2;
        end
    end

    assign w_flags3.no_real_roots = r_disc[DW-1];
    assign w_flags3.not_quadratic = (r_a3 == '0);

    // Square root chain.
    logic           w_sq_valid [SW+1];
    logic [DW-1:0]  w_sq_v     [SW+1];
    logic [SW+1:0]  w_sq_rem   [SW+1];
    logic [SW-1:0]  w_sq_root  [SW+1];
    logic [PLS-1:0] w_sq_pl    [SW+1];

    assign w_sq_valid[0] = r_v3;
    assign w_sq_v[0]     = r_disc;
    assign w_sq_rem[0]   = '0;
    assign w_sq_root[0]  = '0;
    assign w_sq_pl[0]    = {DB'(r_disc), r_a3, r_b3, w_flags3};

    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        qrs_sqrt_cell #(.DW(DW), .SW(SW), .PLW(PLS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_sq_valid[k]),
            .i_v     (w_sq_v[k]),
            .i_rem   (w_sq_rem[k]),
            .i_root  (w_sq_root[k]),
            .i_pl    (w_sq_pl[k]),
            .o_valid (w_sq_valid[k+1]),
            .o_v     (w_sq_v[k+1]),
            .o_rem   (w_sq_rem[k+1]),
            .o_root  (w_sq_root[k+1]),
            .o_pl    (w_sq_pl[k+1])
        );
    end

    // Numerators and divisor magnitude.
    logic [DB-1:0]        w_n_disc;
    logic signed [CW-1:0] w_n_a, w_n_b;
    qrs_pkg::t_qrs_flags  w_n_flags;
    logic signed [NW-1:0] w_s, w_bn, w_np, w_nm;
    logic signed [ADW-1:0] w_a2x;
    logic                 r_vn;
    logic [ADW-1:0]       r_den;
    logic [NW-1:0]        r_mp, r_mm;
    logic [PLD-1:0]       r_pld;
    logic [ADW-1:0]       w_den;
    logic [NW-1:0]        w_mp, w_mm;
    logic                 w_sp, w_sm;

    always_comb begin
        w_n_disc  = w_sq_pl[SW][PLS-1 -: DB];
        w_n_a     = w_sq_pl[SW][2*CW+1 -: CW];
        w_n_b     = w_sq_pl[SW][CW+1 -: CW];
        w_n_flags = w_sq_pl[SW][1:0];
        w_s       = NW'($signed({1'b0, w_sq_root[SW]}));
        w_bn      = NW'(w_n_b);
        w_np      = w_s - w_bn;
        w_nm      = -w_bn - w_s;
        w_a2x     = ADW'(w_n_a) <<< 1;
        w_den     = w_n_a[CW-1] ? ADW'(-w_a2x) : ADW'(w_a2x);
        w_mp      = w_np[NW-1] ? NW'(-w_np) : NW'(w_np);
        w_mm      = w_nm[NW-1] ? NW'(-w_nm) : NW'(w_nm);
        w_sp      = w_np[NW-1] ^ w_n_a[CW-1];
        w_sm      = w_nm[NW-1] ^ w_n_a[CW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vn <= 1'b0;
        end else if (w_adv) begin
            r_vn <= w_sq_valid[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_den <= w_den;
            r_mp  <= w_mp;
            r_mm  <= w_mm;
            r_pld <= {w_n_disc, w_sp, w_sm, w_n_flags};
        end
    end

    // Divider chain.
    logic           w_dv_valid [DNW+1];
    logic [ADW-1:0] w_dv_den   [DNW+1];
    logic [DNW-1:0] w_dv_num_p [DNW+1];
    logic [DNW-1:0] w_dv_num_m [DNW+1];
    logic [ADW-1:0] w_dv_rem_p [DNW+1];
    logic [ADW-1:0] w_dv_rem_m [DNW+1];
    logic [DNW-1:0] w_dv_quo_p [DNW+1];
    logic [DNW-1:0] w_dv_quo_m [DNW+1];
    logic [PLD-1:0] w_dv_pl    [DNW+1];

    assign w_dv_valid[0] = r_vn;
    assign w_dv_den[0]   = r_den;
    assign w_dv_num_p[0] = {r_mp, {qrs_pkg::FRAC_SHIFT{1'b0}}};
    assign w_dv_num_m[0] = {r_mm, {qrs_pkg::FRAC_SHIFT{1'b0}}};
    assign w_dv_rem_p[0] = '0;
    assign w_dv_rem_m[0] = '0;
    assign w_dv_quo_p[0] = '0;
    assign w_dv_quo_m[0] = '0;
    assign w_dv_pl[0]    = r_pld;

    for (genvar k = 0; k < DNW; k++) begin : g_div
        qrs_div_cell #(.DNW(DNW), .ADW(ADW), .PLW(PLD)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_dv_valid[k]),
            .i_den   (w_dv_den[k]),
            .i_num_p (w_dv_num_p[k]),
            .i_num_m (w_dv_num_m[k]),
            .i_rem_p (w_dv_rem_p[k]),
            .i_rem_m (w_dv_rem_m[k]),
            .i_quo_p (w_dv_quo_p[k]),
            .i_quo_m (w_dv_quo_m[k]),
            .i_pl    (w_dv_pl[k]),
            .o_valid (w_dv_valid[k+1]),
            .o_den   (w_dv_den[k+1]),
            .o_num_p (w_dv_num_p[k+1]),
            .o_num_m (w_dv_num_m[k+1]),
            .o_rem_p (w_dv_rem_p[k+1]),
            .o_rem_m (w_dv_rem_m[k+1]),
            .o_quo_p (w_dv_quo_p[k+1]),
            .o_quo_m (w_dv_quo_m[k+1]),
            .o_pl    (w_dv_pl[k+1])
        );
    end

    // Sign and saturation: returns {saturated, root}.
    function automatic logic [RB:0] f_finish(input logic [DNW-1:0] q, input logic neg);
        logic [QX-1:0] qx;
        logic [RB:0]   res;
        qx = QX'(q);
        if (!neg) begin
            if (qx > QX'(qrs_pkg::ROOT_POS_LIMIT)) begin
                res = {1'b1, qrs_pkg::ROOT_POS_MAX};
            end else begin
                res = {1'b0, qx[RB-1:0]};
            end
        end else begin
            if (qx > QX'(qrs_pkg::ROOT_NEG_LIMIT)) begin
                res = {1'b1, qrs_pkg::ROOT_NEG_MIN};
            end else begin
                res = {1'b0, RB'(RB'(0) - qx[RB-1:0])};
            end
        end
        return res;
    endfunction

    qrs_pkg::t_qrs_flags w_f_flags;
    logic                w_active;
    logic [RB:0]         w_fp, w_fm;
    logic                r_ov;
    logic [DB-1:0]       r_disc_o;
    logic [RB-1:0]       r_rp, r_rm;
    qrs_pkg::t_qrs_flags r_flags_o;
    logic                r_sat;

    always_comb begin
        w_f_flags = w_dv_pl[DNW][1:0];
        w_active  = !w_f_flags.no_real_roots && !w_f_flags.not_quadratic;
        w_fp      = f_finish(w_dv_quo_p[DNW], w_dv_pl[DNW][3]);
        w_fm      = f_finish(w_dv_quo_m[DNW], w_dv_pl[DNW][2]);
    end

    assign w_adv       = !r_ov || o_res.ready;
    assign i_req.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= w_dv_valid[DNW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_disc_o  <= w_dv_pl[DNW][PLD-1 -: DB];
            r_flags_o <= w_f_flags;
            r_rp      <= w_active ? w_fp[RB-1:0] : '0;
            r_rm      <= w_active ? w_fm[RB-1:0] : '0;
            r_sat     <= w_active && (w_fp[RB] || w_fm[RB]);
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.discriminant   = r_disc_o;
    assign o_res.root_plus      = r_rp;
    assign o_res.root_minus     = r_rm;
    assign o_res.no_real_roots  = r_flags_o.no_real_roots;
    assign o_res.not_quadratic  = r_flags_o.not_quadratic;
    assign o_res.root_saturated = r_sat;

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_flags_o.no_real_roots || r_flags_o.not_quadratic))
        |-> (r_rp == '0 && r_rm == '0 && !r_sat))
        else $error("flagged result carries nonzero roots");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_sat) |-> (r_rp == qrs_pkg::ROOT_POS_MAX || r_rp == qrs_pkg::ROOT_NEG_MIN
                             || r_rm == qrs_pkg::ROOT_POS_MAX || r_rm == qrs_pkg::ROOT_NEG_MIN))
        else $error("saturation flag without a clamped root");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_res.ready) |=> (r_ov && $stable(r_rp) && $stable(r_rm)))
        else $error("pending result changed during a stall");

    a_chain_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv) |=> $stable(w_dv_valid[DNW]))
        else $error("divider chain moved while stalled");
endmodule
`default_nettype wire
